/* hdl/dsh_pkg.sv */
// Shared constants for the diamond-square heightmap generator.
// Holds default parameter values, register indexes and reset values.
// No dependencies.
`default_nettype none

package dsh_pkg;

   // Default sizing of the grid and the datapath.
   localparam int DEF_MAX_LEVELS    = 8;
   localparam int DEF_HEIGHT_BITS   = 16;
   localparam int DEF_FRACTION_BITS = 16;

   // Width of the level count register.
   localparam int LEVEL_BITS = 4;

   // Register file map.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_HEIGHT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVELS     = 2'd1;

   // Register reset values.
   localparam int RST_MAX_HEIGHT = 4096;
   localparam int RST_LEVELS     = 8;

endpackage

`default_nettype wire

/* hdl/dsh_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the height grid. No dependencies.
`default_nettype none

module dsh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/dsh_mul.sv */
// Shared registered multiplier of the heightmap datapath.
// Used for the random offset, the corner heights and the divide by three.
// No dependencies.
`default_nettype none

module dsh_mul #(
   parameter int WIDTH = 18
) (
   input  wire logic                 clock,
   input  wire logic [WIDTH-1:0]     op_a,
   input  wire logic [WIDTH-1:0]     op_b,
   output logic      [2*WIDTH-1:0]   product
);

   logic [2*WIDTH-1:0] product_ff;

   // The product is registered before anything else uses it.
   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

/* hdl/diamond_square_heightmap.sv */
// Diamond-square heightmap generator, top level with the point sequencer.
// Depends on dsh_pkg, dsh_ram and dsh_mul.
//
// Usage:
//  - The req_ channel carries one random fraction per transfer, scaled by
//    2^FRACTION_BITS; values above one count as one. Every transfer yields
//    exactly one point on the rsp_ channel: row, column, height, and last,
//    which marks the final point of a surface. The next transfer after that
//    starts a new surface at the four corners.
//  - The csr_ channel writes max_height (index 0) and levels (index 1). It is
//    always ready. Writing levels abandons the surface in progress.
//  - Sequence: a corner point goes through ST_MUL, ST_HGT and ST_DONE; an
//    interior point through ST_MUL, ST_READ for up to four neighbor reads
//    from the single read port of the grid memory, ST_LAST, ST_DIV (the shared
//    multiplier used a second time to divide edge sums by three), ST_HGT and
//    ST_DONE. req_stall stays high until the point in work leaves ST_DONE.
//  - A finished point waits in the output register while rsp_stall is high;
//    the next transfer is taken meanwhile, and its result holds until the
//    output register is free.
//  - Reset is synchronous. It restores the register defaults and starts a
//    new surface. The grid memory is not cleared: every read whose data is
//    summed hits a point written earlier in the same surface.
`default_nettype none

module diamond_square_heightmap #(
   parameter int MAX_LEVELS    = dsh_pkg::DEF_MAX_LEVELS,
   parameter int HEIGHT_BITS   = dsh_pkg::DEF_HEIGHT_BITS,
   parameter int FRACTION_BITS = dsh_pkg::DEF_FRACTION_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [FRACTION_BITS:0]             req_random_fraction,
   // Result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [MAX_LEVELS:0]                rsp_row,
   output logic      [MAX_LEVELS:0]                rsp_col,
   output logic      [HEIGHT_BITS-1:0]             rsp_height,
   output logic                                    rsp_last,
   // Register write channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dsh_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [HEIGHT_BITS-1:0]             csr_wdata
);

   localparam int LB        = dsh_pkg::LEVEL_BITS;
   localparam int PW        = MAX_LEVELS + 1;
   localparam int PX        = MAX_LEVELS + 2;
   localparam int HB        = HEIGHT_BITS;
   localparam int FB        = FRACTION_BITS;
   localparam int SUMW      = HB + 2;
   localparam int OPW       = (FB + 1 > SUMW) ? FB + 1 : SUMW;
   localparam int PRW       = 2 * OPW;
   localparam int GRID_SIDE = (1 << MAX_LEVELS) + 1;
   localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
   localparam int AW        = $clog2(DEPTH);

   // Reciprocal of three for sums below 2^SUMW.
   localparam logic [SUMW+1:0] DIV3_NUM  = ((SUMW+2)'(1) << (SUMW + 1)) + (SUMW+2)'(2);
   localparam logic [SUMW+1:0] DIV3_FULL = DIV3_NUM / (SUMW+2)'(3);
   localparam logic [SUMW-1:0] DIV3_RECIP = DIV3_FULL[SUMW-1:0];

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_LAST = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_HGT  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   // Surface phases.
   localparam logic [1:0] PH_CORNER  = 2'd0;
   localparam logic [1:0] PH_DIAMOND = 2'd1;
   localparam logic [1:0] PH_SQUARE  = 2'd2;

   localparam logic [2:0] NB_FULL    = 3'd4;
   localparam logic [1:0] NB_FINAL   = 2'd3;
   localparam logic [1:0] NB_FIRST   = 2'd0;
   localparam logic [LB-1:0] LV_MAX  = LB'(MAX_LEVELS);

   // Flat grid address: row * GRID_SIDE + col.
   function automatic logic [AW-1:0] grid_addr(input logic [PW-1:0] r, input logic [PW-1:0] c);
      grid_addr = (AW'(r) << MAX_LEVELS) + AW'(r) + AW'(c);
   endfunction

   // Control registers.
   logic [2:0]     state_ff, state_in;
   logic [1:0]     phase_ff, phase_in;
   logic [1:0]     corner_cnt_ff, corner_cnt_in;
   logic [LB-1:0]  level_ff, level_in;
   logic [PW-1:0]  cur_row_ff, cur_row_in;
   logic [PW-1:0]  cur_col_ff, cur_col_in;
   logic [HB-1:0]  magnitude_ff, magnitude_in;
   logic [HB-1:0]  max_height_ff, max_height_in;
   logic [LB-1:0]  levels_ff, levels_in;
   logic [1:0]     nb_ff, nb_in;
   logic           pend_ff, pend_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [FB:0]    frac_ff, frac_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [HB-1:0]  rnd_ff, rnd_in;
   logic [HB-1:0]  height_ff, height_in;
   logic [PW-1:0]  rsp_row_ff, rsp_row_in;
   logic [PW-1:0]  rsp_col_ff, rsp_col_in;
   logic [HB-1:0]  rsp_height_ff, rsp_height_in;
   logic           rsp_last_ff, rsp_last_in;

   // Datapath signals.
   logic            is_corner;
   logic [LB-1:0]   eff_lv;
   logic [PW-1:0]   last_pos;
   logic [PW-1:0]   step;
   logic [PW-1:0]   first_step;
   logic [PW-1:0]   pt_row, pt_col;
   logic [PW-1:0]   nb_row, nb_col;
   logic            nb_present;
   logic [PW-1:0]   row_p, row_m, col_p, col_m;
   logic [OPW-1:0]  mul_a, mul_b;
   logic [PRW-1:0]  product;
   logic [PRW-1:0]  rnd_sum;
   logic [HB:0]     corner_v;
   logic [HB-1:0]   corner_h;
   logic [HB-1:0]   avg;
   logic [HB+1:0]   walk_v;
   logic [HB-1:0]   walk_h;
   logic [HB-1:0]   rd_data;
   logic            out_free;
   logic            fire;
   logic [PX-1:0]   ncol, nrow_d, nrow_s;
   logic [FB:0]     frac_sat;

   assign is_corner  = (phase_ff != PH_DIAMOND) && (phase_ff != PH_SQUARE);
   assign eff_lv     = (levels_ff > LV_MAX) ? LV_MAX : levels_ff;
   assign last_pos   = PW'(1) << eff_lv;
   assign step       = PW'(1) << (level_ff - LB'(1));
   assign first_step = PW'(1) << (eff_lv - LB'(1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = (state_ff == ST_DONE) && out_free;

   // Fractions above one saturate to one.
   assign frac_sat = (req_random_fraction[FB] && (|req_random_fraction[FB-1:0])) ?
                     {1'b1, {FB{1'b0}}} : req_random_fraction;

   // Position of the point in work.
   assign pt_row = is_corner ? (corner_cnt_ff[1] ? last_pos : '0) : cur_row_ff;
   assign pt_col = is_corner ? (corner_cnt_ff[0] ? last_pos : '0) : cur_col_ff;

   // Neighbor selection, one neighbor per read cycle.
   assign row_p = cur_row_ff + step;
   assign row_m = cur_row_ff - step;
   assign col_p = cur_col_ff + step;
   assign col_m = cur_col_ff - step;

   always_comb begin
      nb_row     = cur_row_ff;
      nb_col     = cur_col_ff;
      nb_present = 1'b1;
      if (phase_ff == PH_DIAMOND) begin
         case (nb_ff)
            2'd0: begin nb_row = row_m; nb_col = col_m; end
            2'd1: begin nb_row = row_p; nb_col = col_m; end
            2'd2: begin nb_row = row_m; nb_col = col_p; end
            default: begin nb_row = row_p; nb_col = col_p; end
         endcase
      end else begin
         case (nb_ff)
            2'd0: begin nb_row = row_m; nb_present = (cur_row_ff != '0); end
            2'd1: begin nb_col = col_m; nb_present = (cur_col_ff != '0); end
            2'd2: begin nb_row = row_p; nb_present = (cur_row_ff != last_pos); end
            default: begin nb_col = col_p; nb_present = (cur_col_ff != last_pos); end
         endcase
      end
   end

   // Shared multiplier operands.
   always_comb begin
      if (state_ff == ST_DIV) begin
         mul_a = OPW'(sum_ff);
         mul_b = OPW'(DIV3_RECIP);
      end else begin
         mul_a = OPW'(frac_ff);
         mul_b = is_corner ? OPW'(max_height_ff) : OPW'(magnitude_ff);
      end
   end

   dsh_mul #(
      .WIDTH (OPW)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   dsh_ram #(
      .WIDTH (HB),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr (grid_addr(pt_row, pt_col)),
      .wr_data (height_ff),
      .rd_addr (grid_addr(nb_row, nb_col)),
      .rd_data (rd_data)
   );

   // Rounded random offset and corner height from the product.
   assign rnd_sum  = product + (PRW'(1) << (FB - 1));
   assign corner_v = product[FB +: HB + 1];
   assign corner_h = (corner_v > {1'b0, max_height_ff}) ? max_height_ff : corner_v[HB-1:0];

   // Neighbor average, offset and clamp.
   assign avg    = (cnt_ff == NB_FULL) ? sum_ff[SUMW-1:2] : product[SUMW+1 +: HB];
   assign walk_v = {2'b00, avg} + {2'b00, rnd_ff} - {3'b000, magnitude_ff[HB-1:1]};
   always_comb begin
      if (walk_v[HB+1]) begin
         walk_h = '0;
      end else if (walk_v[HB:0] > {1'b0, max_height_ff}) begin
         walk_h = max_height_ff;
      end else begin
         walk_h = walk_v[HB-1:0];
      end
   end

   // Walk positions after the current point.
   assign ncol   = PX'(cur_col_ff) + (PX'(step) << 1);
   assign nrow_d = PX'(cur_row_ff) + (PX'(step) << 1);
   assign nrow_s = PX'(cur_row_ff) + PX'(step);

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      corner_cnt_in = corner_cnt_ff;
      level_in      = level_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      magnitude_in  = magnitude_ff;
      max_height_in = max_height_ff;
      levels_in     = levels_ff;
      nb_in         = nb_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      frac_in       = frac_ff;
      sum_in        = sum_ff;
      rnd_in        = rnd_ff;
      height_in     = height_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_height_in = rsp_height_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               frac_in  = frac_sat;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sum_in   = '0;
            cnt_in   = '0;
            pend_in  = 1'b0;
            nb_in    = NB_FIRST;
            state_in = is_corner ? ST_HGT : ST_READ;
         end
         ST_READ: begin
            if (nb_ff == NB_FIRST) begin
               rnd_in = rnd_sum[FB +: HB];
            end
            if (pend_ff) begin
               sum_in = sum_ff + SUMW'(rd_data);
               cnt_in = cnt_ff + 3'd1;
            end
            pend_in = nb_present;
            nb_in   = nb_ff + 2'd1;
            if (nb_ff == NB_FINAL) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (pend_ff) begin
               sum_in = sum_ff + SUMW'(rd_data);
               cnt_in = cnt_ff + 3'd1;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_HGT;
         end
         ST_HGT: begin
            height_in = is_corner ? corner_h : walk_h;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = pt_row;
               rsp_col_in    = pt_col;
               rsp_height_in = height_ff;
               rsp_last_in   = 1'b0;
               state_in      = ST_IDLE;
               if (is_corner) begin
                  // Corners fill in order; fourth starts first level if any.
                  if (corner_cnt_ff == NB_FINAL) begin
                     corner_cnt_in = '0;
                     magnitude_in  = max_height_ff >> 1;
                     if (eff_lv == '0) begin
                        rsp_last_in = 1'b1;
                        phase_in    = PH_CORNER;
                     end else begin
                        level_in   = eff_lv;
                        phase_in   = PH_DIAMOND;
                        cur_row_in = first_step;
                        cur_col_in = first_step;
                     end
                  end else begin
                     corner_cnt_in = corner_cnt_ff + 2'd1;
                     phase_in      = PH_CORNER;
                  end
               end else if (phase_ff == PH_DIAMOND) begin
                  // Square centers, row by row.
                  cur_col_in = ncol[PW-1:0];
                  if (ncol > PX'(last_pos)) begin
                     cur_col_in = step;
                     cur_row_in = nrow_d[PW-1:0];
                     if (nrow_d > PX'(last_pos)) begin
                        phase_in   = PH_SQUARE;
                        cur_row_in = '0;
                        cur_col_in = step;
                     end
                  end
               end else begin
                  // Edge midpoints, rows alternate their starting column.
                  cur_col_in = ncol[PW-1:0];
                  if (ncol > PX'(last_pos)) begin
                     cur_row_in = nrow_s[PW-1:0];
                     if (nrow_s > PX'(last_pos)) begin
                        magnitude_in = magnitude_ff >> 1;
                        if (level_ff <= LB'(1)) begin
                           rsp_last_in   = 1'b1;
                           phase_in      = PH_CORNER;
                           corner_cnt_in = '0;
                           level_in      = '0;
                           cur_row_in    = '0;
                           cur_col_in    = '0;
                        end else begin
                           level_in   = level_ff - LB'(1);
                           phase_in   = PH_DIAMOND;
                           cur_row_in = step >> 1;
                           cur_col_in = step >> 1;
                        end
                     end else begin
                        cur_col_in = ((nrow_s[PW-1:0] & step) != '0) ? '0 : step;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; a new level count restarts the surface.
      if (csr_valid && csr_ready) begin
         if (csr_index == dsh_pkg::CSR_MAX_HEIGHT) begin
            max_height_in = csr_wdata;
         end else if (csr_index == dsh_pkg::CSR_LEVELS) begin
            levels_in     = csr_wdata[LB-1:0];
            phase_in      = PH_CORNER;
            corner_cnt_in = '0;
            level_in      = '0;
            cur_row_in    = '0;
            cur_col_in    = '0;
            magnitude_in  = '0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_CORNER;
         corner_cnt_ff <= '0;
         level_ff      <= '0;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         magnitude_ff  <= '0;
         max_height_ff <= HB'(dsh_pkg::RST_MAX_HEIGHT);
         levels_ff     <= LB'(dsh_pkg::RST_LEVELS);
         nb_ff         <= '0;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         corner_cnt_ff <= corner_cnt_in;
         level_ff      <= level_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         magnitude_ff  <= magnitude_in;
         max_height_ff <= max_height_in;
         levels_ff     <= levels_in;
         nb_ff         <= nb_in;
         pend_ff       <= pend_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      frac_ff       <= frac_in;
      sum_ff        <= sum_in;
      rnd_ff        <= rnd_in;
      height_ff     <= height_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_height_ff <= rsp_height_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_height = rsp_height_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire
